// ===== rtl/core/ihar_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihar_pkg
// Shared types and codes of the hex address resolver: item kinds, address
// modes, result status codes, sequencer states and fill constants.
// ----------------------------------------------------------------------------
package ihar_pkg;

	typedef enum logic [2:0] {
		KIND_DATA      = 3'd0,
		KIND_EXT_SEG   = 3'd1,
		KIND_EXT_LIN   = 3'd2,
		KIND_START_SEG = 3'd3,
		KIND_START_LIN = 3'd4,
		KIND_EOF       = 3'd5,
		KIND_BEGIN     = 3'd6,
		KIND_RSVD      = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		MODE_8BIT    = 3'd0,
		MODE_16BIT   = 3'd1,
		MODE_32BIT   = 3'd2,
		MODE_ENDED   = 3'd3,
		MODE_ERR_END = 3'd4,
		MODE_ERR_LIN = 3'd5,
		MODE_ERR_SEG = 3'd6
	} addr_mode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_AFTER_END = 2'd1,
		STAT_LIN_IN_SEG = 2'd2,
		STAT_SEG_IN_LIN = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PLAN,
		ST_FILL,
		ST_LAST
	} state_t;

	localparam logic [7:0] FILL_BYTE = 8'hFF;
	localparam logic [5:0] ALIGN_16  = 6'd16;
	localparam logic [5:0] ALIGN_32  = 6'd32;

endpackage

// ===== rtl/core/intel_hex_address_resolver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_address_resolver_core
// Resolves decoded hex record events into byte writes, with 0xFF gap and
// boundary fill, address mode tracking and sticky error status.
// Steps: a non-data item is accepted, then executed; a data byte is accepted,
// its address formed in execute, then planned and written, or planned, padded
// with 0xFF fill bytes and written in the last state, all on one shared address adder.
// Throughput: one item at a time; the input stalls until the item's last beat
// is loaded into the output register. Output stall holds the sequencer.
// Reset: 8-bit mode, base and highest address zero, nothing written, align 0.
// ----------------------------------------------------------------------------
module intel_hex_address_resolver_core
	import ihar_pkg::*;
#(
	parameter int MAX_ALIGN  = 32,
	parameter int ADDR_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [5:0]  cfg_write_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [15:0] record_offset,
	input  logic [7:0]  byte_index,
	input  logic [7:0]  data_value,
	input  logic [7:0]  addr_byte_hi,
	input  logic [7:0]  addr_byte_lo,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        write_valid,
	output logic [31:0] mem_address,
	output logic [7:0]  mem_byte,
	output logic        last,
	output logic [1:0]  status,
	output logic [1:0]  mode_out,
	output logic        file_done
);

	localparam int CW = $clog2(MAX_ALIGN);
	localparam logic [6:0] MAX_ALIGN_W = 7'(MAX_ALIGN);
	localparam logic [ADDR_WIDTH-1:0] ALL_ONES = '1;

	// control state
	state_t     state_q, state_d;
	addr_mode_t mode_q, mode_d;
	logic [5:0] align_q;
	logic       any_q, any_d;
	logic [ADDR_WIDTH-1:0] base_q, base_d;
	logic [ADDR_WIDTH-1:0] high_q, high_d;

	// item registers
	kind_t      kind_q;
	logic [15:0] rel_q;
	logic [7:0] data_q;
	logic [7:0] hi_q;
	logic [7:0] lo_q;

	// sequencer work registers
	logic [ADDR_WIDTH-1:0] eff_q, eff_d;
	logic [ADDR_WIDTH-1:0] fa_q, fa_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic                  gap_q, gap_d;

	// output register
	logic                  ovalid_q;
	logic                  owv_q, owv_d;
	logic [ADDR_WIDTH-1:0] oaddr_q, oaddr_d;
	logic [7:0]            obyte_q, obyte_d;
	logic                  olast_q, olast_d;
	status_t               ostat_q, ostat_d;
	logic [1:0]            omode_q, omode_d;
	logic                  odone_q, odone_d;
	logic                  emit;

	// shared address adder
	logic [ADDR_WIDTH-1:0] op_a, op_b, sum;
	logic                  cin;

	logic accept, out_free, fill_en;

	assign accept   = in_valid && !in_stall;
	assign out_free = !ovalid_q || !out_stall;
	assign fill_en  = any_q && (align_q == ALIGN_16 || align_q == ALIGN_32) &&
		({1'b0, align_q} <= MAX_ALIGN_W);
	assign sum = op_a + op_b + ADDR_WIDTH'(cin);

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		any_d   = any_q;
		base_d  = base_q;
		high_d  = high_q;
		eff_d   = eff_q;
		fa_d    = fa_q;
		cnt_d   = cnt_q;
		gap_d   = gap_q;
		op_a    = '0;
		op_b    = '0;
		cin     = 1'b0;
		emit    = 1'b0;
		owv_d   = 1'b0;
		oaddr_d = '0;
		obyte_d = '0;
		olast_d = 1'b1;
		ostat_d = STAT_OK;
		omode_d = '0;
		odone_d = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				op_a = (mode_q == MODE_8BIT) ? '0 : base_q;
				op_b = ADDR_WIDTH'(rel_q);
				if (kind_q == KIND_DATA && mode_q != MODE_ENDED && mode_q != MODE_ERR_END &&
						mode_q != MODE_ERR_LIN && mode_q != MODE_ERR_SEG) begin
					eff_d   = sum;
					state_d = ST_PLAN;
				end else if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					if (kind_q == KIND_BEGIN) begin
						mode_d = MODE_8BIT;
						base_d = '0;
						high_d = '0;
						any_d  = 1'b0;
					end else if (kind_q == KIND_RSVD) begin
						ostat_d = STAT_OK;
					end else if (mode_q == MODE_ERR_END) begin
						ostat_d = STAT_AFTER_END;
					end else if (mode_q == MODE_ERR_LIN) begin
						ostat_d = STAT_LIN_IN_SEG;
					end else if (mode_q == MODE_ERR_SEG) begin
						ostat_d = STAT_SEG_IN_LIN;
					end else if (mode_q == MODE_ENDED) begin
						mode_d  = MODE_ERR_END;
						ostat_d = STAT_AFTER_END;
					end else if (kind_q == KIND_EOF) begin
						omode_d = 2'(mode_q);
						odone_d = 1'b1;
						mode_d  = MODE_ENDED;
					end else if (kind_q == KIND_EXT_SEG || kind_q == KIND_START_SEG) begin
						if (mode_q == MODE_32BIT) begin
							mode_d  = MODE_ERR_SEG;
							ostat_d = STAT_SEG_IN_LIN;
						end else begin
							mode_d = MODE_16BIT;
							if (kind_q == KIND_EXT_SEG) begin
								base_d = ADDR_WIDTH'({hi_q, lo_q, 4'h0});
							end
						end
					end else begin
						// linear records
						if (mode_q == MODE_16BIT) begin
							mode_d  = MODE_ERR_LIN;
							ostat_d = STAT_LIN_IN_SEG;
						end else begin
							mode_d = MODE_32BIT;
							if (kind_q == KIND_EXT_LIN) begin
								base_d = ADDR_WIDTH'({hi_q, lo_q, 16'h0});
							end
						end
					end
				end
			end
			ST_PLAN: begin
				// gap above the highest written address
				op_a = eff_q;
				op_b = ~high_q;
				cin  = 1'b1;
				if (fill_en && sum < ADDR_WIDTH'(align_q) && sum > ADDR_WIDTH'(1)) begin
					cnt_d   = sum[CW-1:0] - CW'(1);
					gap_d   = 1'b1;
					state_d = ST_FILL;
				end else if (fill_en && !(sum < ADDR_WIDTH'(align_q)) &&
						(eff_q[5:0] & (align_q - 6'd1)) != 6'd0 && eff_q[1:0] != 2'd0) begin
					cnt_d   = CW'(eff_q[1:0]);
					fa_d    = eff_q;
					gap_d   = 1'b0;
					state_d = ST_FILL;
				end else if (out_free) begin
					emit    = 1'b1;
					owv_d   = 1'b1;
					oaddr_d = eff_q;
					obyte_d = data_q;
					any_d   = 1'b1;
					if (!any_q || eff_q > high_q) begin
						high_d = eff_q;
					end
					state_d = ST_IDLE;
				end
			end
			ST_FILL: begin
				op_a = gap_q ? high_q : fa_q;
				op_b = gap_q ? '0 : ALL_ONES;
				cin  = gap_q;
				if (out_free) begin
					emit    = 1'b1;
					owv_d   = 1'b1;
					oaddr_d = sum;
					obyte_d = FILL_BYTE;
					olast_d = 1'b0;
					if (gap_q) begin
						high_d = sum;
					end else begin
						fa_d = sum;
					end
					cnt_d = cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_d = ST_LAST;
					end
				end
			end
			ST_LAST: begin
				if (out_free) begin
					emit    = 1'b1;
					owv_d   = 1'b1;
					oaddr_d = eff_q;
					obyte_d = data_q;
					any_d   = 1'b1;
					if (!any_q || eff_q > high_q) begin
						high_d = eff_q;
					end
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= MODE_8BIT;
			align_q  <= '0;
			any_q    <= 1'b0;
			base_q   <= '0;
			high_q   <= '0;
			ovalid_q <= 1'b0;
			cnt_q    <= '0;
			gap_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			any_q   <= any_d;
			base_q  <= base_d;
			high_q  <= high_d;
			cnt_q   <= cnt_d;
			gap_q   <= gap_d;
			if (cfg_write_en) begin
				align_q <= cfg_write_data;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (!out_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(kind);
			rel_q  <= record_offset + 16'(byte_index);
			data_q <= data_value;
			hi_q   <= addr_byte_hi;
			lo_q   <= addr_byte_lo;
		end
		eff_q <= eff_d;
		fa_q  <= fa_d;
		if (emit) begin
			owv_q   <= owv_d;
			oaddr_q <= oaddr_d;
			obyte_q <= obyte_d;
			olast_q <= olast_d;
			ostat_q <= ostat_d;
			omode_q <= omode_d;
			odone_q <= odone_d;
		end
	end

	assign in_stall    = state_q != ST_IDLE;
	assign out_valid   = ovalid_q;
	assign write_valid = owv_q;
	assign mem_address = 32'(oaddr_q);
	assign mem_byte    = obyte_q;
	assign last        = olast_q;
	assign status      = ostat_q;
	assign mode_out    = omode_q;
	assign file_done   = odone_q;

	// an accepted beat always starts the execute step
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_EXEC)
		else $error("accepted item did not enter execute");

	// fill loop never runs with an empty count
	a_fill_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FILL |-> cnt_q != '0)
		else $error("fill state with zero count");

	// end of file and error results are single, non-writing beats
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (file_done || status != STAT_OK) |-> last && !write_valid)
		else $error("status or end-of-file beat malformed");

	// a non-last fill beat only shows while the fill sequence runs
	a_fill_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid && mem_byte == FILL_BYTE && !last |->
		state_q == ST_FILL || state_q == ST_LAST)
		else $error("fill beat outside fill sequence");

endmodule

// ===== tb/intel_hex_address_resolver_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// intel_hex_address_resolver_core_test
// Self-checking bench for the hex address resolver. Decoded record events go
// in over a valid/stall channel. A behavioral model of the resolver keeps its
// own mode, base, high-water mark and fill setting, and queues the write and
// status beats that each accepted event should produce. Every output beat is
// compared with the oldest queued beat. Directed events cover addressing
// modes, wraps, sticky errors and both kinds of 0xFF fill. Random hex files
// then run under several fill settings with shifting idle patterns and one
// long output hold.
// ----------------------------------------------------------------------------
module intel_hex_address_resolver_core_test;
	import ihar_pkg::*;

	localparam int QUIET_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 200;
	localparam int CFG_GAP      = 4;
	localparam int DRAIN_CYCLES = 40;

	typedef struct {
		logic        wr;
		logic [31:0] addr;
		logic [7:0]  data;
		logic        fin;
		status_t     stat;
		logic [1:0]  mode;
		logic        done;
	} beat_t;

	logic        clk;
	logic        arst_n         = 1'b0;
	logic        cfg_write_en   = 1'b0;
	logic [5:0]  cfg_write_data = 6'd0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [2:0]  kind           = 3'd0;
	logic [15:0] record_offset  = 16'd0;
	logic [7:0]  byte_index     = 8'd0;
	logic [7:0]  data_value     = 8'd0;
	logic [7:0]  addr_byte_hi   = 8'd0;
	logic [7:0]  addr_byte_lo   = 8'd0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic        write_valid;
	logic [31:0] mem_address;
	logic [7:0]  mem_byte;
	logic        last;
	logic [1:0]  status;
	logic [1:0]  mode_out;
	logic        file_done;

	// resolver model state
	addr_mode_t  res_mode  = MODE_8BIT;
	logic [31:0] res_base  = '0;
	logic [31:0] res_high  = '0;
	bit          res_any   = 1'b0;
	logic [5:0]  align_reg = '0;

	beat_t resolved_beats[$];

	int  send_idle_pct = 12;
	int  recv_idle_pct = 78;
	logic hold_off     = 1'b0;
	event hold_go;

	int fail_count   = 0;
	int items_sent   = 0;
	int beats_seen   = 0;
	int fill_beats   = 0;
	int error_beats  = 0;
	int quiet_cycles = 0;

	intel_hex_address_resolver_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.record_offset  (record_offset),
		.byte_index     (byte_index),
		.data_value     (data_value),
		.addr_byte_hi   (addr_byte_hi),
		.addr_byte_lo   (addr_byte_lo),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.write_valid    (write_valid),
		.mem_address    (mem_address),
		.mem_byte       (mem_byte),
		.last           (last),
		.status         (status),
		.mode_out       (mode_out),
		.file_done      (file_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic void push_beat(logic wr, logic [31:0] addr, logic [7:0] data,
			logic fin, status_t stat, logic [1:0] mode, logic done);
		beat_t b;
		b.wr   = wr;
		b.addr = addr;
		b.data = data;
		b.fin  = fin;
		b.stat = stat;
		b.mode = mode;
		b.done = done;
		resolved_beats.push_back(b);
	endfunction

	function automatic void push_note(status_t stat);
		push_beat(1'b0, '0, '0, 1'b1, stat, 2'd0, 1'b0);
	endfunction

	function automatic void push_fill(logic [31:0] addr);
		push_beat(1'b1, addr, FILL_BYTE, 1'b0, STAT_OK, 2'd0, 1'b0);
		fill_beats++;
	endfunction

	// expected beats for one accepted event, state updated as the block does
	function automatic void resolve_item(kind_t k, logic [15:0] off, logic [7:0] idx,
			logic [7:0] val, logic [7:0] hi, logic [7:0] lo);
		logic [15:0] rel;
		logic [31:0] eff, gap, a;
		int i;
		if (k == KIND_BEGIN) begin
			res_mode = MODE_8BIT;
			res_base = '0;
			res_high = '0;
			res_any  = 1'b0;
			push_note(STAT_OK);
			return;
		end
		if (k == KIND_RSVD) begin
			push_note(STAT_OK);
			return;
		end
		case (res_mode)
			MODE_ERR_END: begin
				push_note(STAT_AFTER_END);
				return;
			end
			MODE_ERR_LIN: begin
				push_note(STAT_LIN_IN_SEG);
				return;
			end
			MODE_ERR_SEG: begin
				push_note(STAT_SEG_IN_LIN);
				return;
			end
			MODE_ENDED: begin
				res_mode = MODE_ERR_END;
				push_note(STAT_AFTER_END);
				return;
			end
			default: ;
		endcase
		case (k)
			KIND_EOF: begin
				push_beat(1'b0, '0, '0, 1'b1, STAT_OK, 2'(res_mode), 1'b1);
				res_mode = MODE_ENDED;
			end
			KIND_EXT_SEG, KIND_START_SEG: begin
				if (res_mode == MODE_32BIT) begin
					res_mode = MODE_ERR_SEG;
					push_note(STAT_SEG_IN_LIN);
				end else begin
					res_mode = MODE_16BIT;
					if (k == KIND_EXT_SEG)
						res_base = {12'd0, hi, lo, 4'd0};
					push_note(STAT_OK);
				end
			end
			KIND_EXT_LIN, KIND_START_LIN: begin
				if (res_mode == MODE_16BIT) begin
					res_mode = MODE_ERR_LIN;
					push_note(STAT_LIN_IN_SEG);
				end else begin
					res_mode = MODE_32BIT;
					if (k == KIND_EXT_LIN)
						res_base = {hi, lo, 16'd0};
					push_note(STAT_OK);
				end
			end
			default: begin
				rel = off + idx;
				eff = (res_mode == MODE_8BIT) ? {16'd0, rel} : res_base + {16'd0, rel};
				if ((align_reg == ALIGN_16 || align_reg == ALIGN_32) && res_any) begin
					gap = eff - res_high;
					if (gap < {26'd0, align_reg}) begin
						// close the short gap above the high-water mark
						while (gap > 1) begin
							a = res_high + 1;
							push_fill(a);
							res_high = a;
							gap--;
						end
					end else if ((eff & ({26'd0, align_reg} - 1)) != 0) begin
						// pad down to the word boundary below the byte
						for (i = 1; i <= eff[1:0]; i++)
							push_fill(eff - i);
					end
				end
				push_beat(1'b1, eff, val, 1'b1, STAT_OK, 2'd0, 1'b0);
				if (!res_any || eff > res_high)
					res_high = eff;
				res_any = 1'b1;
			end
		endcase
	endfunction

	task automatic send_item(kind_t k, logic [15:0] off, logic [7:0] idx, logic [7:0] val,
			logic [7:0] hi, logic [7:0] lo);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		kind          <= k;
		record_offset <= off;
		byte_index    <= idx;
		data_value    <= val;
		addr_byte_hi  <= hi;
		addr_byte_lo  <= lo;
		do @(posedge clk); while (in_stall);
		resolve_item(k, off, idx, val, hi, lo);
		if (k != KIND_RSVD)
			items_sent++;
	endtask

	task automatic send_ctl(kind_t k);
		send_item(k, rnd16(), rnd8(), rnd8(), rnd8(), rnd8());
	endtask

	task automatic set_align(logic [5:0] val);
		in_valid <= 1'b0;
		while (resolved_beats.size() != 0)
			@(posedge clk);
		repeat (CFG_GAP) @(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		align_reg = val;
	endtask

	// modes, offset wraps, sticky errors, reserved kind, end of file
	task automatic test_addressing();
		send_ctl(KIND_BEGIN);
		send_item(KIND_DATA, 16'hFFFF, 8'hFF, 8'h00, 8'h00, 8'h00);
		send_item(KIND_EXT_SEG, 16'h0000, 8'h00, 8'h00, 8'hFF, 8'hFF);
		send_item(KIND_DATA, 16'hFFFF, 8'h00, 8'hFF, 8'hFF, 8'hFF);
		send_item(KIND_EXT_LIN, rnd16(), rnd8(), rnd8(), 8'h12, 8'h34);
		send_ctl(KIND_DATA);
		send_ctl(KIND_BEGIN);
		send_item(KIND_EXT_LIN, 16'h0000, 8'h00, 8'h00, 8'hFF, 8'hFF);
		send_item(KIND_DATA, 16'hFFFF, 8'hFF, 8'hA5, 8'h00, 8'h00);
		send_ctl(KIND_START_SEG);
		send_ctl(KIND_BEGIN);
		send_ctl(KIND_START_LIN);
		send_ctl(KIND_EOF);
		send_ctl(KIND_DATA);
		send_ctl(KIND_RSVD);
		send_ctl(KIND_BEGIN);
		send_ctl(KIND_EOF);
	endtask

	// overwrite at the high mark, gap fill, boundary pad, a long gap at 32
	task automatic test_fill();
		set_align(ALIGN_16);
		send_ctl(KIND_BEGIN);
		send_item(KIND_DATA, 16'h0100, 8'd0, 8'h11, 8'h00, 8'h00);
		send_item(KIND_DATA, 16'h0100, 8'd0, 8'h22, 8'h00, 8'h00);
		send_item(KIND_DATA, 16'h0100, 8'd5, 8'h33, 8'h00, 8'h00);
		send_item(KIND_DATA, 16'h0200, 8'd3, 8'h44, 8'h00, 8'h00);
		send_item(KIND_DATA, 16'h0300, 8'd8, 8'h55, 8'h00, 8'h00);
		set_align(ALIGN_32);
		send_item(KIND_DATA, 16'h0300, 8'h26, 8'h66, 8'h00, 8'h00);
	endtask

	task automatic send_random_file();
		int n_rec, n_bytes, r, j;
		logic [15:0] cursor, off;
		bit linear;
		send_ctl(KIND_BEGIN);
		r = $urandom_range(0, 9);
		linear = (r >= 6);
		if (r >= 3) begin
			send_ctl(linear ? KIND_EXT_LIN : KIND_EXT_SEG);
			if ($urandom_range(0, 2) == 0)
				send_ctl(linear ? KIND_START_LIN : KIND_START_SEG);
		end
		cursor = rnd16();
		n_rec = $urandom_range(1, 5);
		for (r = 0; r < n_rec; r++) begin
			// mostly just past the previous record so the gap logic gets exercised
			if ($urandom_range(0, 7) == 0)
				off = rnd16();
			else
				off = cursor + 16'($urandom_range(0, 40)) - 16'd6;
			n_bytes = $urandom_range(1, 6);
			for (j = 0; j < n_bytes; j++)
				send_item(KIND_DATA, off, ($urandom_range(0, 9) == 0) ? rnd8() : 8'(j),
					rnd8(), rnd8(), rnd8());
			cursor = off + 16'(n_bytes);
			case ($urandom_range(0, 11))
				0: send_ctl(kind_t'($urandom_range(1, 4)));
				1: send_ctl(KIND_RSVD);
				2: send_ctl(linear ? KIND_EXT_LIN : KIND_EXT_SEG);
				default: ;
			endcase
		end
		if ($urandom_range(0, 9) != 0) begin
			send_ctl(KIND_EOF);
			if ($urandom_range(0, 3) == 0)
				send_ctl(kind_t'($urandom_range(0, 5)));
		end
	endtask

	task automatic test_random_files(int n);
		int target;
		target = items_sent + n;
		while (items_sent < target)
			send_random_file();
	endtask

	// output held for a long stretch while closely spaced bytes keep coming
	task automatic test_backpressure();
		logic [15:0] off;
		int j;
		send_ctl(KIND_BEGIN);
		off = 16'h4000;
		-> hold_go;
		for (j = 0; j < 16; j++) begin
			send_item(KIND_DATA, off, 8'd0, rnd8(), rnd8(), rnd8());
			off = off + 16'($urandom_range(2, 14));
		end
		send_ctl(KIND_EOF);
	endtask

	initial begin
		forever begin
			@(hold_go);
			hold_off <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	always @(posedge clk)
		out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_beats
		beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			beats_seen++;
			if (resolved_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual addr %h byte %h status %0d",
					$time, mem_address, mem_byte, status);
				fail_count++;
			end else begin
				want = resolved_beats.pop_front();
				if (want.stat != STAT_OK)
					error_beats++;
				check_field("write_valid", want.wr, write_valid);
				check_field("mem_address", want.addr, mem_address);
				check_field("mem_byte", want.data, mem_byte);
				check_field("last", want.fin, last);
				check_field("status", want.stat, status);
				check_field("mode_out", want.mode, mode_out);
				check_field("file_done", want.done, file_done);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles, %0d beats outstanding", $time,
				quiet_cycles, resolved_beats.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_addressing();
		test_fill();

		set_align(ALIGN_16);
		test_random_files(40);

		send_idle_pct = 78;
		recv_idle_pct = 12;
		set_align(ALIGN_32);
		test_backpressure();
		test_random_files(30);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_align(6'd31);
		test_random_files(20);
		set_align(6'd0);
		test_random_files(20);

		in_valid <= 1'b0;
		while (resolved_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d events and %0d result beats: %0d fill bytes, %0d error results",
			items_sent, beats_seen, fill_beats, error_beats);
		$display("fill settings 0, 16, 31 and 32, with input and output idling and a long hold");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
